// ----- src/assert_macros.svh -----
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define MFSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mfse assertion failed");

// Condition must never be true outside reset.
`define MFSE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("mfse forbidden condition seen");

`endif

// ----- src/mfse_pkg.sv -----
// ---------------------------------------------------------------------------
// mfse_pkg
// Shared types and codes of the multipart file stream extractor.
// ---------------------------------------------------------------------------
package mfse_pkg;

  // Result event codes (carried on the master tuser)
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_FOUND    = 3'd1;
  localparam logic [2:0] EV_START    = 3'd2;
  localparam logic [2:0] EV_DATA     = 3'd3;
  localparam logic [2:0] EV_COMPLETE = 3'd4;

  // Configuration register indexes
  localparam logic CFG_MARKER_BYTES = 1'b0;
  localparam logic CFG_MARKER_LEN   = 1'b1;

  // Characters
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Reset values of the configuration registers
  localparam logic [63:0] MARKER_BYTES_RST = 64'h0000_0000_0A0D_0A0D;
  localparam logic [3:0]  MARKER_LEN_RST   = 4'd4;

  // Entries of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PREFIX_LEN  = 4;

  typedef struct packed {
    logic [63:0] marker_bytes;
    logic [3:0]  marker_len;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Boundary delimiter prefix: CR LF "--"
  function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CH_CR;
      2'd1:    b = CH_LF;
      default: b = CH_HYPHEN;
    endcase
    return b;
  endfunction

endpackage

// ----- src/multipart_file_stream_extractor_core.sv -----
// Multipart file stream extractor. Takes one body byte per transfer and
// reports parse events: file found, data start, data bytes and completion.
// The front end accepts one byte per cycle while its four-entry command
// queue has room. Each byte normally yields one result; a byte that breaks
// a partial boundary match in the file body yields n+1 results, where n is
// the number of held boundary bytes (up to BOUNDARY_MAX-1). The back end
// delivers one result per cycle while the output is not stalled, reading
// held bytes from the boundary store through its second read port, so a
// mismatch burst holds the input once the queue fills. The boundary store
// needs no clearing after reset.
// ---------------------------------------------------------------------------
// multipart_file_stream_extractor_core
// Top level: configuration registers, front end, queue and back end.
// ---------------------------------------------------------------------------
module multipart_file_stream_extractor_core import mfse_pkg::*; #(
  parameter int unsigned BOUNDARY_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output logic        m_axis_tlast
);

  localparam int unsigned AW = $clog2(BOUNDARY_MAX);
  localparam int unsigned EW = 3 + AW + 8;

  cfg_t          cfg_q;
  q_stat_t       q_stat;
  logic          push;
  logic [EW-1:0] push_data;
  logic          pop;
  logic [EW-1:0] head;
  logic [AW-1:0] rb_addr;
  logic [7:0]    rb_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker_bytes <= MARKER_BYTES_RST;
      cfg_q.marker_len   <= MARKER_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MARKER_BYTES: cfg_q.marker_bytes <= cfg_wdata_i;
        CFG_MARKER_LEN:   cfg_q.marker_len   <= cfg_wdata_i[3:0];
        default:          cfg_q.marker_len   <= cfg_q.marker_len;
      endcase
    end
  end

  mfse_front #(
    .BOUNDARY_MAX(BOUNDARY_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_data_o(push_data),
    .rb_addr_i  (rb_addr),
    .rb_data_o  (rb_data)
  );

  mfse_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  mfse_back #(
    .BOUNDARY_MAX(BOUNDARY_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .rb_addr_o  (rb_addr),
    .rb_data_i  (rb_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_event_o(m_axis_tuser),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ----- src/mfse_front.sv -----
// ---------------------------------------------------------------------------
// mfse_front
// Byte classifier: parse phases, boundary store and per-byte command issue.
// ---------------------------------------------------------------------------
module mfse_front import mfse_pkg::*; #(
  parameter int unsigned BOUNDARY_MAX = 64,
  localparam int unsigned AW = $clog2(BOUNDARY_MAX),
  localparam int unsigned EW = 3 + AW + 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_data_i,
  output logic          in_ready_o,
  input  q_stat_t       q_stat_i,
  output logic          push_o,
  output logic [EW-1:0] push_data_o,   // {event, held count, byte}
  input  logic [AW-1:0] rb_addr_i,
  output logic [7:0]    rb_data_o
);

  localparam logic [3:0] PH_INIT     = 4'd0;
  localparam logic [3:0] PH_SKIP     = 4'd1;
  localparam logic [3:0] PH_CR       = 4'd2;
  localparam logic [3:0] PH_LF       = 4'd3;
  localparam logic [3:0] PH_HYPHEN   = 4'd4;
  localparam logic [3:0] PH_BOUND    = 4'd5;
  localparam logic [3:0] PH_BOUND_CR = 4'd6;
  localparam logic [3:0] PH_HEADER   = 4'd7;
  localparam logic [3:0] PH_FILE     = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  logic [3:0]    phase_q, phase_d;
  logic [AW:0]   blen_q, blen_d;
  logic [AW-1:0] mc_q, mc_d;
  logic [7:0]    mem [BOUNDARY_MAX];
  logic [7:0]    want_q;
  logic          wr_en;
  logic          accept;
  logic [2:0]    ev;
  logic [AW-1:0] held;
  logic [7:0]    c;
  logic [3:0]    mlen;
  logic [7:0]    mwant;
  logic [3:0]    mc_hdr_inc;
  logic [AW:0]   mc_inc;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_data_i;

  // Effective marker length, clamped to 1..8
  always_comb begin
    if (cfg_i.marker_len == 4'd0) begin
      mlen = 4'd1;
    end else if (cfg_i.marker_len > 4'd8) begin
      mlen = 4'd8;
    end else begin
      mlen = cfg_i.marker_len;
    end
  end

  assign mwant      = cfg_i.marker_bytes[{mc_q[2:0], 3'b000} +: 8];
  assign mc_hdr_inc = {1'b0, mc_q[2:0]} + 4'd1;
  assign mc_inc     = {1'b0, mc_q} + {{AW{1'b0}}, 1'b1};

  // Phase transitions and command for each accepted byte
  always_comb begin
    phase_d = phase_q;
    blen_d  = blen_q;
    mc_d    = mc_q;
    wr_en   = 1'b0;
    ev      = EV_NONE;
    held    = '0;
    unique case (phase_q)
      PH_INIT: begin
        if (c == CH_CR) begin
          phase_d = PH_CR;
        end else if (c == CH_HYPHEN) begin
          phase_d = PH_HYPHEN;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (c == CH_CR) begin
          phase_d = PH_CR;
        end else if (c == CH_LF) begin
          phase_d = PH_LF;
        end
      end
      PH_CR:     phase_d = (c == CH_LF) ? PH_LF : PH_SKIP;
      PH_LF:     phase_d = (c == CH_HYPHEN) ? PH_HYPHEN : PH_SKIP;
      PH_HYPHEN: begin
        if (c == CH_HYPHEN) begin
          phase_d = PH_BOUND;
          blen_d  = (AW+1)'(PREFIX_LEN);
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_BOUND: begin
        if (c == CH_CR) begin
          phase_d = PH_BOUND_CR;
        end else if (c < CH_SPACE || c > CH_TILDE ||
                     blen_q >= (AW+1)'(BOUNDARY_MAX)) begin
          phase_d = PH_SKIP;
          blen_d  = '0;
        end else begin
          wr_en  = 1'b1;
          blen_d = blen_q + {{AW{1'b0}}, 1'b1};
        end
      end
      PH_BOUND_CR: begin
        if (c == CH_LF) begin
          phase_d = PH_HEADER;
          mc_d    = '0;
          ev      = EV_FOUND;
        end else begin
          phase_d = PH_SKIP;
          blen_d  = '0;
        end
      end
      PH_HEADER: begin
        if (c != mwant) begin
          mc_d = '0;
        end else if (mc_hdr_inc >= mlen) begin
          phase_d = PH_FILE;
          mc_d    = '0;
          ev      = EV_START;
        end else begin
          mc_d = AW'(mc_hdr_inc);
        end
      end
      PH_FILE: begin
        if (c != want_q) begin
          // replay held boundary bytes plus this byte
          ev   = EV_DATA;
          held = mc_q;
          mc_d = '0;
        end else if (mc_inc >= blen_q) begin
          phase_d = PH_DONE;
          ev      = EV_COMPLETE;
        end else begin
          mc_d = mc_inc[AW-1:0];
        end
      end
      PH_DONE:  ev = EV_COMPLETE;
      default:  ev = EV_NONE;
    endcase
  end

  assign push_o      = accept;
  assign push_data_o = {ev, held, c};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INIT;
      blen_q  <= '0;
      mc_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      blen_q  <= blen_d;
      mc_q    <= mc_d;
    end
  end

  // Boundary store: prefix entries are constant, token bytes are written
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[blen_q[AW-1:0]] <= c;
    end
  end

  // Port A: prefetch of the next expected boundary byte
  always_ff @(posedge clk_i) begin
    if (accept ? (mc_d < AW'(PREFIX_LEN)) : (mc_q < AW'(PREFIX_LEN))) begin
      want_q <= prefix_byte(accept ? mc_d[1:0] : mc_q[1:0]);
    end else begin
      want_q <= mem[accept ? mc_d : mc_q];
    end
  end

  // Port B: replay reads for the back end
  always_ff @(posedge clk_i) begin
    if (rb_addr_i < AW'(PREFIX_LEN)) begin
      rb_data_o <= prefix_byte(rb_addr_i[1:0]);
    end else begin
      rb_data_o <= mem[rb_addr_i];
    end
  end

endmodule

// ----- src/mfse_queue.sv -----
// ---------------------------------------------------------------------------
// mfse_queue
// Small register FIFO carrying commands from the front to the back end.
// ---------------------------------------------------------------------------
module mfse_queue import mfse_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output q_stat_t          stat_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/mfse_back.sv -----
// ---------------------------------------------------------------------------
// mfse_back
// Result sequencer: turns commands into result transfers, replaying held
// boundary bytes from the store on a mismatch.
// ---------------------------------------------------------------------------
module mfse_back import mfse_pkg::*; #(
  parameter int unsigned BOUNDARY_MAX = 64,
  localparam int unsigned AW = $clog2(BOUNDARY_MAX),
  localparam int unsigned EW = 3 + AW + 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [EW-1:0] head_i,
  input  q_stat_t       q_stat_i,
  output logic          pop_o,
  output logic [AW-1:0] rb_addr_o,
  input  logic [7:0]    rb_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    out_event_o,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);

  logic          ov_q, ov_d;
  logic [2:0]    oev_q, oev_d;
  logic [7:0]    obyte_q, obyte_d;
  logic          olast_q, olast_d;
  logic          run_q, run_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] n_q, n_d;
  logic [7:0]    c_q, c_d;
  logic          load;
  logic [2:0]    h_ev;
  logic [AW-1:0] h_n;
  logic [7:0]    h_byte;

  assign h_ev   = head_i[EW-1 -: 3];
  assign h_n    = head_i[8 +: AW];
  assign h_byte = head_i[7:0];
  assign load   = !ov_q || out_ready_i;

  // Next result selection
  always_comb begin
    ov_d    = ov_q;
    oev_d   = oev_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    run_d   = run_q;
    k_d     = k_q;
    n_d     = n_q;
    c_d     = c_q;
    pop_o   = 1'b0;
    if (load) begin
      priority if (run_q) begin
        ov_d  = 1'b1;
        oev_d = EV_DATA;
        if (k_q < n_q) begin
          obyte_d = rb_data_i;
          olast_d = 1'b0;
          k_d     = k_q + AW'(1);
        end else begin
          obyte_d = c_q;
          olast_d = 1'b1;
          run_d   = 1'b0;
          k_d     = '0;
        end
      end else if (!q_stat_i.empty) begin
        pop_o = 1'b1;
        ov_d  = 1'b1;
        oev_d = h_ev;
        if (h_ev == EV_DATA && h_n != '0) begin
          // first held byte; store port already reads entry zero
          obyte_d = rb_data_i;
          olast_d = 1'b0;
          k_d     = AW'(1);
          run_d   = 1'b1;
          n_d     = h_n;
          c_d     = h_byte;
        end else if (h_ev == EV_DATA) begin
          obyte_d = h_byte;
          olast_d = 1'b1;
        end else begin
          obyte_d = '0;
          olast_d = 1'b1;
        end
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  assign rb_addr_o = k_d;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      run_q <= 1'b0;
      k_q   <= '0;
    end else begin
      ov_q  <= ov_d;
      run_q <= run_d;
      k_q   <= k_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    oev_q   <= oev_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    n_q     <= n_d;
    c_q     <= c_d;
  end

  assign out_valid_o = ov_q;
  assign out_event_o = oev_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

// ----- src/mfse_checker.sv -----
// ---------------------------------------------------------------------------
// mfse_checker
// Port-level checks of the extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfse_checker import mfse_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled result holds its content
  `MFSE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // only defined event codes leave the block
  `MFSE_NEVER(a_ev_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser > EV_COMPLETE)

  // non-data events are single results with a zero byte
  `MFSE_ASSERT(a_ev_single, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != EV_DATA |-> m_axis_tlast && m_axis_tdata == 8'd0)

  // input back-pressure only while a result is waiting
  `MFSE_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid)

endmodule

bind multipart_file_stream_extractor_core mfse_checker u_mfse_checker (.*);
